FILE: rtl/v3rot_pkg.sv
// Types, constants and helpers shared by the axis rotator.
// No dependencies; compile first.
`default_nettype none

package v3rot_pkg;

  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned NumSteps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  localparam logic signed [31:0] CordicGain = 32'sd652032874;
  localparam logic [31:0] EighthTurn = 32'h2000_0000;
  localparam logic signed [31:0] ResidualBias = 32'sd536870912;
  localparam logic signed [65:0] RoundHalf = 66'sd536870912;
  localparam logic signed [65:0] OutMax = 66'sd2147483647;
  localparam logic signed [65:0] OutMin = -66'sd2147483648;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_e;

  typedef struct packed {
    axis_e              kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    point_t             pt;
    logic [1:0]         quad;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } cordic_t;

  function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
    logic signed [31:0] val;
    case (idx)
      5'd0:    val = 32'sh2000_0000;
      5'd1:    val = 32'sh12E4_051E;
      5'd2:    val = 32'sh09FB_385B;
      5'd3:    val = 32'sh0511_11D4;
      5'd4:    val = 32'sh028B_0D43;
      5'd5:    val = 32'sh0145_D7E1;
      5'd6:    val = 32'sh00A2_F61E;
      5'd7:    val = 32'sh0051_7C55;
      5'd8:    val = 32'sh0028_BE53;
      5'd9:    val = 32'sh0014_5F2F;
      5'd10:   val = 32'sh000A_2F98;
      5'd11:   val = 32'sh0005_17CC;
      5'd12:   val = 32'sh0002_8BE6;
      5'd13:   val = 32'sh0001_45F3;
      5'd14:   val = 32'sh0000_A2FA;
      5'd15:   val = 32'sh0000_517D;
      5'd16:   val = 32'sh0000_28BE;
      5'd17:   val = 32'sh0000_145F;
      5'd18:   val = 32'sh0000_0A30;
      5'd19:   val = 32'sh0000_0518;
      5'd20:   val = 32'sh0000_028C;
      5'd21:   val = 32'sh0000_0146;
      5'd22:   val = 32'sh0000_00A3;
      5'd23:   val = 32'sh0000_0051;
      5'd24:   val = 32'sh0000_0029;
      5'd25:   val = 32'sh0000_0014;
      5'd26:   val = 32'sh0000_000A;
      5'd27:   val = 32'sh0000_0005;
      5'd28:   val = 32'sh0000_0003;
      5'd29:   val = 32'sh0000_0001;
      5'd30:   val = 32'sh0000_0001;
      default: val = 32'sh0000_0000;
    endcase
    return val;
  endfunction

  // round half up at bit 30, then clamp to 32-bit signed
  function automatic logic signed [31:0] round_sat(input logic signed [65:0] acc);
    logic signed [65:0] r;
    logic signed [31:0] res;
    r = (acc + RoundHalf) >>> 30;
    if (r > OutMax) begin
      res = 32'sh7FFF_FFFF;
    end else if (r < OutMin) begin
      res = 32'sh8000_0000;
    end else begin
      res = $signed(r[31:0]);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/v3rot_if.sv
// Valid/ready channels for the axis rotator: input point and angle, output point.
// Stand-alone; compile after v3rot_pkg.
`default_nettype none

interface v3rot_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] x_in;
  logic signed [31:0] y_in;
  logic signed [31:0] z_in;
  logic [15:0]        turn_angle;

  modport source (output valid, output kind, output x_in, output y_in, output z_in,
                  output turn_angle, input ready);
  modport sink (input valid, input kind, input x_in, input y_in, input z_in,
                input turn_angle, output ready);
endinterface

interface v3rot_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_out;
  logic signed [31:0] y_out;
  logic signed [31:0] z_out;

  modport source (output valid, output x_out, output y_out, output z_out, input ready);
  modport sink (input valid, input x_out, input y_out, input z_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/vec3_axis_rotator.sv
// Axis rotator top level: pipelined CORDIC sin/cos, quadrant fix, products, rounding.
// Register stages in order: input capture, the CORDIC iterations, quadrant fix and operand select, products, output.
// Throughput: one transfer per cycle while the output is not stalled; one CORDIC iteration per register stage.
// A stage holds while the next one is full and stalled; bubbles are squeezed out.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data is not reset.
// Depends on v3rot_pkg and v3rot_if.
`default_nettype none

module vec3_axis_rotator (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  v3rot_in_if.sink    in_i,
  v3rot_out_if.source out_o
);

  localparam int unsigned Steps = v3rot_pkg::NumSteps;
  localparam int unsigned SelIdx = Steps + 1;
  localparam int unsigned MulIdx = Steps + 2;
  localparam int unsigned OutIdx = Steps + 3;
  localparam int unsigned StageCnt = Steps + 4;

  logic [StageCnt-1:0] v_q;
  logic [StageCnt-1:0] en;

  v3rot_pkg::cordic_t cor_q [Steps+1];
  v3rot_pkg::cordic_t cor_d;
  logic [31:0]        ang_b;

  logic signed [32:0] c_d, s_d, c_q, s_q;
  logic signed [31:0] p_d, r_d, p_q, r_q;
  v3rot_pkg::point_t  pt_sel_q, pt_mul_q;

  logic signed [64:0] pc_q, rs_q, ps_q, rc_q;

  logic signed [31:0] pn, rn;
  logic signed [31:0] xo_d, yo_d, zo_d, xo_q, yo_q, zo_q;

  // stage enables: advance when empty or when the next stage advances
  always_comb begin
    en[OutIdx] = !v_q[OutIdx] || out_o.ready;
    for (int k = OutIdx - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < StageCnt; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // angle to quadrant and residual in [-1/8, 1/8) turn
  always_comb begin
    ang_b         = {in_i.turn_angle, 16'h0000} + v3rot_pkg::EighthTurn;
    cor_d.pt.kind = v3rot_pkg::axis_e'(in_i.kind);
    cor_d.pt.x    = in_i.x_in;
    cor_d.pt.y    = in_i.y_in;
    cor_d.pt.z    = in_i.z_in;
    cor_d.quad    = ang_b[31:30];
    cor_d.cx      = v3rot_pkg::CordicGain;
    cor_d.cy      = '0;
    cor_d.cz      = $signed({2'b00, ang_b[29:0]}) - v3rot_pkg::ResidualBias;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      cor_q[0] <= cor_d;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic signed [31:0] dx, dy, at;
    v3rot_pkg::cordic_t nxt;

    always_comb begin
      dx  = cor_q[k].cy >>> k;
      dy  = cor_q[k].cx >>> k;
      at  = v3rot_pkg::atan_entry(5'(k));
      nxt = cor_q[k];
      if (!cor_q[k].cz[31]) begin
        nxt.cx = cor_q[k].cx - dx;
        nxt.cy = cor_q[k].cy + dy;
        nxt.cz = cor_q[k].cz - at;
      end else begin
        nxt.cx = cor_q[k].cx + dx;
        nxt.cy = cor_q[k].cy - dy;
        nxt.cz = cor_q[k].cz + at;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k+1]) begin
        cor_q[k+1] <= nxt;
      end
    end
  end

  // quadrant fix and operand pair select
  always_comb begin
    case (cor_q[Steps].quad)
      2'd0: begin
        c_d = 33'(cor_q[Steps].cx);
        s_d = 33'(cor_q[Steps].cy);
      end
      2'd1: begin
        c_d = -33'(cor_q[Steps].cy);
        s_d = 33'(cor_q[Steps].cx);
      end
      2'd2: begin
        c_d = -33'(cor_q[Steps].cx);
        s_d = -33'(cor_q[Steps].cy);
      end
      default: begin
        c_d = 33'(cor_q[Steps].cy);
        s_d = -33'(cor_q[Steps].cx);
      end
    endcase
    case (cor_q[Steps].pt.kind)
      v3rot_pkg::AXIS_X: begin
        p_d = cor_q[Steps].pt.y;
        r_d = cor_q[Steps].pt.z;
      end
      v3rot_pkg::AXIS_Y: begin
        p_d = cor_q[Steps].pt.x;
        r_d = cor_q[Steps].pt.z;
      end
      default: begin
        p_d = cor_q[Steps].pt.x;
        r_d = cor_q[Steps].pt.y;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[SelIdx]) begin
      c_q      <= c_d;
      s_q      <= s_d;
      p_q      <= p_d;
      r_q      <= r_d;
      pt_sel_q <= cor_q[Steps].pt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[MulIdx]) begin
      pc_q     <= 65'(p_q) * 65'(c_q);
      rs_q     <= 65'(r_q) * 65'(s_q);
      ps_q     <= 65'(p_q) * 65'(s_q);
      rc_q     <= 65'(r_q) * 65'(c_q);
      pt_mul_q <= pt_sel_q;
    end
  end

  always_comb begin
    pn   = v3rot_pkg::round_sat(66'(pc_q) - 66'(rs_q));
    rn   = v3rot_pkg::round_sat(66'(ps_q) + 66'(rc_q));
    xo_d = pt_mul_q.x;
    yo_d = pt_mul_q.y;
    zo_d = pt_mul_q.z;
    case (pt_mul_q.kind)
      v3rot_pkg::AXIS_X: begin
        yo_d = pn;
        zo_d = rn;
      end
      v3rot_pkg::AXIS_Y: begin
        xo_d = pn;
        zo_d = rn;
      end
      v3rot_pkg::AXIS_Z: begin
        xo_d = pn;
        yo_d = rn;
      end
      default: begin
        xo_d = pt_mul_q.x;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[OutIdx]) begin
      xo_q <= xo_d;
      yo_q <= yo_d;
      zo_q <= zo_d;
    end
  end

  assign out_o.valid = v_q[OutIdx];
  assign out_o.x_out = xo_q;
  assign out_o.y_out = yo_q;
  assign out_o.z_out = zo_q;

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> v_q[0])
    else $error("input stalled with empty first stage");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && !en[0] |=> v_q[0])
    else $error("stalled first stage lost its item");

  a_drain_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en[OutIdx] |-> en[0])
    else $error("pipeline blocked while output advances");

endmodule

`default_nettype wire
